@@ rtl/tcf_pkg.sv @@
package tcf_pkg;

    localparam int ENERGY_BITS = 10;
    localparam int SIDE        = 5;
    localparam int IDX_W       = 3;

    // Fixed field widths of the channels.
    localparam int IN_W        = 10;
    localparam int BIN_W       = 3;
    localparam int TOT_OUT_W   = 15;
    localparam int CL_OUT_W    = 14;

    // Internal widths follow from the energy width.
    localparam int LINE_W = ENERGY_BITS + 3;   // sum of five crystals
    localparam int WIN_W  = ENERGY_BITS + 2;   // sum of three crystals
    localparam int CL_W   = ENERGY_BITS + 4;   // sum of nine crystals
    localparam int TOT_W  = ENERGY_BITS + 5;   // sum of 25 crystals
    localparam int WGT_W  = ENERGY_BITS + 8;   // weighted strip sum, up to 4.5 times the total

    typedef logic [ENERGY_BITS-1:0] t_energy;
    typedef logic [LINE_W-1:0]      t_line_sum;
    typedef logic [WIN_W-1:0]       t_win_sum;
    typedef logic [IDX_W-1:0]       t_idx;

    typedef struct packed {
        logic wr;
        t_idx row;
    } t_lane_ctl;

    typedef struct packed {
        logic wr;
        t_idx row;
        logic calc_sum;
        logic calc_bin;
        logic load_out;
    } t_merge_ctl;

endpackage

@@ rtl/tcf_row_if.sv @@
interface tcf_row_if;
    logic                    valid;
    logic                    ready;
    logic [tcf_pkg::IN_W-1:0] row_crystal_0;
    logic [tcf_pkg::IN_W-1:0] row_crystal_1;
    logic [tcf_pkg::IN_W-1:0] row_crystal_2;
    logic [tcf_pkg::IN_W-1:0] row_crystal_3;
    logic [tcf_pkg::IN_W-1:0] row_crystal_4;

    modport source (
        output valid, row_crystal_0, row_crystal_1, row_crystal_2, row_crystal_3,
               row_crystal_4,
        input  ready
    );
    modport sink (
        input  valid, row_crystal_0, row_crystal_1, row_crystal_2, row_crystal_3,
               row_crystal_4,
        output ready
    );
endinterface

@@ rtl/tcf_res_if.sv @@
interface tcf_res_if;
    logic                          valid;
    logic                          ready;
    logic [tcf_pkg::BIN_W-1:0]     peak_row;
    logic [tcf_pkg::BIN_W-1:0]     peak_column;
    logic [tcf_pkg::TOT_OUT_W-1:0] tower_total;
    logic [tcf_pkg::CL_OUT_W-1:0]  cluster_total;

    modport source (
        output valid, peak_row, peak_column, tower_total, cluster_total,
        input  ready
    );
    modport sink (
        input  valid, peak_row, peak_column, tower_total, cluster_total,
        output ready
    );
endinterface

@@ rtl/tcf_lane.sv @@
module tcf_lane (
    input  logic                i_clk,
    input  tcf_pkg::t_lane_ctl  i_ctl,
    input  tcf_pkg::t_energy    i_crystal,
    input  tcf_pkg::t_idx       i_peak_row,
    output tcf_pkg::t_line_sum  o_col_sum,
    output tcf_pkg::t_win_sum   o_win_sum
);

    tcf_pkg::t_energy   r_crystal [tcf_pkg::SIDE];
    tcf_pkg::t_line_sum r_col_sum;
    tcf_pkg::t_line_sum n_col_sum;
    tcf_pkg::t_win_sum  win_sum;

    // The first row of a tower restarts the column sum.
    always_comb begin
        if (i_ctl.row == '0) begin
            n_col_sum = tcf_pkg::LINE_W'(i_crystal);
        end else begin
            n_col_sum = r_col_sum + tcf_pkg::LINE_W'(i_crystal);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_crystal[i_ctl.row] <= i_crystal;
            r_col_sum            <= n_col_sum;
        end
    end

    // Crystals of the peak row and of the rows next to it; rows off the edge are skipped.
    always_comb begin
        win_sum = '0;
        for (int j = 0; j < tcf_pkg::SIDE; j++) begin
            if ((4'(j) + 4'd1 >= 4'(i_peak_row)) && (4'(j) <= 4'(i_peak_row) + 4'd1)) begin
                win_sum = win_sum + tcf_pkg::WIN_W'(r_crystal[j]);
            end
        end
    end

    assign o_col_sum = r_col_sum;
    assign o_win_sum = win_sum;

endmodule

@@ rtl/tcf_merge.sv @@
module tcf_merge (
    input  logic                                i_clk,
    input  tcf_pkg::t_merge_ctl                 i_ctl,
    input  tcf_pkg::t_energy                    i_crystal [tcf_pkg::SIDE],
    input  tcf_pkg::t_line_sum                  i_col_sum [tcf_pkg::SIDE],
    input  tcf_pkg::t_win_sum                   i_win_sum [tcf_pkg::SIDE],
    output tcf_pkg::t_idx                       o_peak_row,
    output logic [tcf_pkg::BIN_W-1:0]           o_out_peak_row,
    output logic [tcf_pkg::BIN_W-1:0]           o_out_peak_column,
    output logic [tcf_pkg::TOT_OUT_W-1:0]       o_out_tower_total,
    output logic [tcf_pkg::CL_OUT_W-1:0]        o_out_cluster_total
);

    typedef logic [tcf_pkg::WGT_W-1:0] t_wgt;
    typedef logic [tcf_pkg::TOT_W-1:0] t_tot;

    tcf_pkg::t_line_sum r_row_sum [tcf_pkg::SIDE];
    t_tot               r_total;
    t_wgt               r_wgt_row;
    t_wgt               r_wgt_col;
    tcf_pkg::t_idx      r_peak_row;
    tcf_pkg::t_idx      r_peak_col;
    logic [tcf_pkg::BIN_W-1:0]     r_out_peak_row;
    logic [tcf_pkg::BIN_W-1:0]     r_out_peak_col;
    logic [tcf_pkg::TOT_OUT_W-1:0] r_out_total;
    logic [tcf_pkg::CL_OUT_W-1:0]  r_out_cluster;

    tcf_pkg::t_line_sum row_sum;
    t_tot               total;
    logic [tcf_pkg::CL_W-1:0] cluster;

    // Strip weights 0.5, 1.5, 2.5, 3.5 and 4.5, each half product truncated.
    function automatic t_wgt weigh(input tcf_pkg::t_line_sum s [tcf_pkg::SIDE]);
        t_wgt v0, v1, v2, v3, v4;
        v0 = t_wgt'(s[0]);
        v1 = t_wgt'(s[1]);
        v2 = t_wgt'(s[2]);
        v3 = t_wgt'(s[3]);
        v4 = t_wgt'(s[4]);
        return (v0 >> 1) + v1 + (v1 >> 1) + (v2 << 1) + (v2 >> 1)
             + (v3 << 2) - (v3 >> 1) + (v4 << 2) + (v4 >> 1);
    endfunction

    // First k with w <= (k+1) * total, else the last bin.
    function automatic tcf_pkg::t_idx bin_of(input t_wgt w, input t_tot t);
        t_wgt t1, t2, t3, t4;
        tcf_pkg::t_idx k;
        t1 = t_wgt'(t);
        t2 = t1 << 1;
        t3 = t2 + t1;
        t4 = t1 << 2;
        priority if (w <= t1) k = 3'd0;
        else if (w <= t2)     k = 3'd1;
        else if (w <= t3)     k = 3'd2;
        else if (w <= t4)     k = 3'd3;
        else                  k = 3'd4;
        return k;
    endfunction

    always_comb begin
        row_sum = '0;
        total   = '0;
        for (int p = 0; p < tcf_pkg::SIDE; p++) begin
            row_sum = row_sum + tcf_pkg::LINE_W'(i_crystal[p]);
            total   = total + tcf_pkg::TOT_W'(i_col_sum[p]);
        end
    end

    // Pick the three column windows around the peak column.
    always_comb begin
        cluster = '0;
        for (int p = 0; p < tcf_pkg::SIDE; p++) begin
            if ((4'(p) + 4'd1 >= 4'(r_peak_col)) && (4'(p) <= 4'(r_peak_col) + 4'd1)) begin
                cluster = cluster + tcf_pkg::CL_W'(i_win_sum[p]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_row_sum[i_ctl.row] <= row_sum;
        end
        if (i_ctl.calc_sum) begin
            r_total   <= total;
            r_wgt_row <= weigh(r_row_sum);
            r_wgt_col <= weigh(i_col_sum);
        end
        if (i_ctl.calc_bin) begin
            r_peak_row <= bin_of(r_wgt_row, r_total);
            r_peak_col <= bin_of(r_wgt_col, r_total);
        end
        if (i_ctl.load_out) begin
            r_out_peak_row <= tcf_pkg::BIN_W'(r_peak_row);
            r_out_peak_col <= tcf_pkg::BIN_W'(r_peak_col);
            r_out_total    <= tcf_pkg::TOT_OUT_W'(r_total);
            r_out_cluster  <= tcf_pkg::CL_OUT_W'(cluster);
        end
    end

    assign o_peak_row          = r_peak_row;
    assign o_out_peak_row      = r_out_peak_row;
    assign o_out_peak_column   = r_out_peak_col;
    assign o_out_tower_total   = r_out_total;
    assign o_out_cluster_total = r_out_cluster;

endmodule

@@ rtl/tower_cluster_finder_unit.sv @@
// Takes one eta row per cycle while idle; rows one to four give no result.
// After the fifth row the result beat goes through the registered steps strip sums,
// peak bins and 3x3 window sum; the last waits while the result register is full.
// The peak sequencer has three steps; no row of the next tower is taken until it is idle.
// Reset (synchronous, active low) clears the row counter, the sequencer and
// the result valid flag; stored crystals and sums are rewritten by each tower.
module tower_cluster_finder_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tcf_row_if.sink       i_row,
    tcf_res_if.source     o_res
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SUM  = 4'b0010,
        ST_BIN  = 4'b0100,
        ST_CLU  = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    tcf_pkg::t_idx r_row, n_row;
    logic          r_out_valid, n_out_valid;

    logic                accept;
    logic                load_out;
    tcf_pkg::t_lane_ctl  lane_ctl;
    tcf_pkg::t_merge_ctl merge_ctl;
    tcf_pkg::t_energy    crystal   [tcf_pkg::SIDE];
    tcf_pkg::t_line_sum  col_sum   [tcf_pkg::SIDE];
    tcf_pkg::t_win_sum   win_sum   [tcf_pkg::SIDE];
    tcf_pkg::t_idx       peak_row;

    assign crystal[0] = i_row.row_crystal_0[tcf_pkg::ENERGY_BITS-1:0];
    assign crystal[1] = i_row.row_crystal_1[tcf_pkg::ENERGY_BITS-1:0];
    assign crystal[2] = i_row.row_crystal_2[tcf_pkg::ENERGY_BITS-1:0];
    assign crystal[3] = i_row.row_crystal_3[tcf_pkg::ENERGY_BITS-1:0];
    assign crystal[4] = i_row.row_crystal_4[tcf_pkg::ENERGY_BITS-1:0];

    assign i_row.ready = (r_state == ST_IDLE);
    assign accept      = i_row.valid && i_row.ready;
    // The result register is free when empty or being drained this cycle.
    assign load_out    = (r_state == ST_CLU) && (!r_out_valid || o_res.ready);

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (r_row == tcf_pkg::IDX_W'(tcf_pkg::SIDE - 1)) begin
                        n_row   = '0;
                        n_state = ST_SUM;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
            end
            ST_SUM: n_state = ST_BIN;
            ST_BIN: n_state = ST_CLU;
            ST_CLU: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

    assign lane_ctl.wr  = accept;
    assign lane_ctl.row = r_row;

    assign merge_ctl.wr       = accept;
    assign merge_ctl.row      = r_row;
    assign merge_ctl.calc_sum = (r_state == ST_SUM);
    assign merge_ctl.calc_bin = (r_state == ST_BIN);
    assign merge_ctl.load_out = load_out;

    for (genvar g = 0; g < tcf_pkg::SIDE; g++) begin : g_lane
        tcf_lane u_lane (
            .i_clk      (i_clk),
            .i_ctl      (lane_ctl),
            .i_crystal  (crystal[g]),
            .i_peak_row (peak_row),
            .o_col_sum  (col_sum[g]),
            .o_win_sum  (win_sum[g])
        );
    end

    tcf_merge u_merge (
        .i_clk               (i_clk),
        .i_ctl               (merge_ctl),
        .i_crystal           (crystal),
        .i_col_sum           (col_sum),
        .i_win_sum           (win_sum),
        .o_peak_row          (peak_row),
        .o_out_peak_row      (o_res.peak_row),
        .o_out_peak_column   (o_res.peak_column),
        .o_out_tower_total   (o_res.tower_total),
        .o_out_cluster_total (o_res.cluster_total)
    );

    assign o_res.valid = r_out_valid;

endmodule

@@ tb/tower_cluster_finder_unit_tb.sv @@
`timescale 1ns / 100ps

module tower_cluster_finder_unit_tb;

    typedef logic [tcf_pkg::IN_W-1:0]      t_crystal;
    typedef t_crystal [tcf_pkg::SIDE-1:0]  t_row_bus;
    typedef t_row_bus [tcf_pkg::SIDE-1:0]  t_tower;

    typedef struct {
        logic [tcf_pkg::BIN_W-1:0]     peak_row;
        logic [tcf_pkg::BIN_W-1:0]     peak_column;
        logic [tcf_pkg::TOT_OUT_W-1:0] tower_total;
        logic [tcf_pkg::CL_OUT_W-1:0]  cluster_total;
    } t_peak_result;

    typedef enum int {
        FILL_UNIFORM,
        FILL_SMALL,
        FILL_SPARSE,
        FILL_EXTREME
    } t_fill_kind;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tcf_row_if row_bus ();
    tcf_res_if res_bus ();

    tower_cluster_finder_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_row   (row_bus),
        .o_res   (res_bus)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow of the tower being assembled.
    int unsigned  tower_cells [tcf_pkg::SIDE][tcf_pkg::SIDE];
    int unsigned  row_energy [tcf_pkg::SIDE];
    int unsigned  col_energy [tcf_pkg::SIDE];
    int unsigned  fill_row;
    t_peak_result pending_peaks [$];
    int unsigned  fail_count;
    bit           back_to_back;

    // Bin of the half-integer weighted centroid of one strip-sum vector.
    function automatic int unsigned centroid_bin(
        input logic [tcf_pkg::SIDE-1:0][15:0] strip,
        input int unsigned total);
        int unsigned s0, s1, s2, s3, s4;
        int unsigned w;
        int unsigned bin;
        s0  = strip[0];
        s1  = strip[1];
        s2  = strip[2];
        s3  = strip[3];
        s4  = strip[4];
        w   = (s0 >> 1) + s1 + (s1 >> 1) + (s2 << 1) + (s2 >> 1)
            + (s3 << 2) - (s3 >> 1) + (s4 << 2) + (s4 >> 1);
        bin = 4;
        for (int k = 3; k >= 0; k--) begin
            if (w <= (k + 1) * total) begin
                bin = k;
            end
        end
        return bin;
    endfunction

    // Takes one accepted row into the shadow tower; after the fifth row it
    // queues the peaks, the total and the 3x3 sum that the block must give.
    task automatic absorb_row(input t_row_bus row);
        int unsigned                    e;
        int unsigned                    line;
        int unsigned                    total;
        int unsigned                    pr;
        int unsigned                    pc;
        int unsigned                    cl;
        int                             ce;
        int                             cp;
        logic [tcf_pkg::SIDE-1:0][15:0] rows_v;
        logic [tcf_pkg::SIDE-1:0][15:0] cols_v;
        t_peak_result                   res;
        line = 0;
        for (int p = 0; p < tcf_pkg::SIDE; p++) begin
            e = row[p] & ((1 << tcf_pkg::ENERGY_BITS) - 1);
            tower_cells[fill_row][p] = e;
            line = line + e;
            col_energy[p] = (col_energy[p] + e) & 16'h1FFF;
        end
        row_energy[fill_row] = line & 16'h1FFF;
        if (fill_row < tcf_pkg::SIDE - 1) begin
            fill_row++;
        end else begin
            total = 0;
            for (int p = 0; p < tcf_pkg::SIDE; p++) begin
                total     = total + col_energy[p];
                rows_v[p] = 16'(row_energy[p]);
                cols_v[p] = 16'(col_energy[p]);
            end
            pr = centroid_bin(rows_v, total);
            pc = centroid_bin(cols_v, total);
            cl = 0;
            for (int de = -1; de <= 1; de++) begin
                for (int dp = -1; dp <= 1; dp++) begin
                    ce = int'(pr) + de;
                    cp = int'(pc) + dp;
                    if (ce >= 0 && ce < tcf_pkg::SIDE && cp >= 0 && cp < tcf_pkg::SIDE) begin
                        cl = cl + tower_cells[ce][cp];
                    end
                end
            end
            res.peak_row      = tcf_pkg::BIN_W'(pr);
            res.peak_column   = tcf_pkg::BIN_W'(pc);
            res.tower_total   = tcf_pkg::TOT_OUT_W'(total);
            res.cluster_total = tcf_pkg::CL_OUT_W'(cl);
            pending_peaks.push_back(res);
            fill_row = 0;
            for (int p = 0; p < tcf_pkg::SIDE; p++) begin
                col_energy[p] = 0;
            end
        end
    endtask

    // Sends one row beat after a random gap and waits for it to be taken.
    task automatic send_row(input t_row_bus row);
        int unsigned gap;
        gap = back_to_back ? 0 : $urandom_range(0, 18);
        repeat (gap) begin
            @(negedge i_clk);
            row_bus.valid = 1'b0;
        end
        @(negedge i_clk);
        row_bus.valid         = 1'b1;
        row_bus.row_crystal_0 = row[0];
        row_bus.row_crystal_1 = row[1];
        row_bus.row_crystal_2 = row[2];
        row_bus.row_crystal_3 = row[3];
        row_bus.row_crystal_4 = row[4];
        do @(posedge i_clk); while (!row_bus.ready);
        absorb_row(row);
    endtask

    task automatic send_tower(input t_tower tw);
        for (int r = 0; r < tcf_pkg::SIDE; r++) begin
            send_row(tw[r]);
        end
    endtask

    task automatic run_empty_tower();
        t_tower tw;
        tw = '0;
        send_tower(tw);
    endtask

    task automatic run_full_scale_tower();
        t_tower tw;
        for (int r = 0; r < tcf_pkg::SIDE; r++) begin
            for (int p = 0; p < tcf_pkg::SIDE; p++) begin
                tw[r][p] = '1;
            end
        end
        send_tower(tw);
    endtask

    // A single hot crystal at either corner and at the center drives the
    // peaks to bins 0, 4 and 2, with the 3x3 window clipped at the edges.
    task automatic run_single_hot_crystal();
        t_tower tw;
        tw       = '0;
        tw[0][0] = '1;
        send_tower(tw);
        tw       = '0;
        tw[4][4] = '1;
        send_tower(tw);
        tw       = '0;
        tw[2][2] = 10'd513;
        send_tower(tw);
    endtask

    function automatic t_crystal draw_energy(input t_fill_kind kind);
        t_crystal e;
        case (kind)
            FILL_SMALL: begin
                e = t_crystal'($urandom_range(0, 3));
            end
            FILL_SPARSE: begin
                e = ($urandom_range(0, 7) == 0) ? t_crystal'($urandom_range(0, 1023)) : '0;
            end
            FILL_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       e = '0;
                    1:       e = '1;
                    2:       e = 10'h200;
                    default: e = 10'h1FF;
                endcase
            end
            default: begin
                e = t_crystal'($urandom_range(0, 1023));
            end
        endcase
        return e;
    endfunction

    // Small values put many towers right on a bin boundary, sparse ones move
    // the peak toward the edges.
    task automatic run_random_towers(input int unsigned n_towers);
        t_tower     tw;
        t_fill_kind kind;
        for (int t = 0; t < n_towers; t++) begin
            back_to_back = ($urandom_range(0, 3) == 0);
            kind         = t_fill_kind'($urandom_range(0, 3));
            for (int r = 0; r < tcf_pkg::SIDE; r++) begin
                for (int p = 0; p < tcf_pkg::SIDE; p++) begin
                    tw[r][p] = draw_energy(kind);
                end
            end
            send_tower(tw);
        end
        back_to_back = 1'b0;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_peak_result want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_peaks.size() == 0) begin
                $error("result beat with no tower pending");
                fail_count++;
            end else begin
                want = pending_peaks.pop_front();
                check_field("peak_row", want.peak_row, res_bus.peak_row);
                check_field("peak_column", want.peak_column, res_bus.peak_column);
                check_field("tower_total", want.tower_total, res_bus.tower_total);
                check_field("cluster_total", want.cluster_total, res_bus.cluster_total);
            end
        end
    end

    initial begin
        res_bus.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            int unsigned stall;
            stall = back_to_back ? 0 : $urandom_range(0, 18);
            repeat (stall) begin
                @(negedge i_clk);
                res_bus.ready = 1'b0;
            end
            @(negedge i_clk);
            res_bus.ready = 1'b1;
            do @(posedge i_clk); while (!res_bus.valid);
        end
    end

    initial begin
        #5_000_000;
        $display("tower_cluster_finder_unit_tb: done, errors");
        $finish;
    end

    initial begin
        i_rst_n               = 1'b0;
        row_bus.valid         = 1'b0;
        row_bus.row_crystal_0 = '0;
        row_bus.row_crystal_1 = '0;
        row_bus.row_crystal_2 = '0;
        row_bus.row_crystal_3 = '0;
        row_bus.row_crystal_4 = '0;
        fill_row              = 0;
        fail_count            = 0;
        back_to_back          = 1'b0;
        for (int p = 0; p < tcf_pkg::SIDE; p++) begin
            col_energy[p] = 0;
        end
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        run_empty_tower();
        run_full_scale_tower();
        run_single_hot_crystal();
        run_random_towers(365);

        @(negedge i_clk);
        row_bus.valid = 1'b0;
        while (pending_peaks.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tower_cluster_finder_unit_tb: done, clean");
        end else begin
            $display("tower_cluster_finder_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/tcf_pkg.sv
rtl/tcf_row_if.sv
rtl/tcf_res_if.sv
rtl/tcf_lane.sv
rtl/tcf_merge.sv
rtl/tower_cluster_finder_unit.sv
tb/tower_cluster_finder_unit_tb.sv
